/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL file that carries checks (the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert that a condition is never true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hw/rtl/jlh_pkg.sv */
// Shared types, constants and the mix step of the lookup2 hash engine.
package jlh_pkg;

   localparam logic [31:0] Golden = 32'h9e3779b9;
   localparam int MixSteps = 9;
   localparam int BlockBytes = 12;
   localparam logic [3:0] LastStep = 4'(MixSteps - 1);
   localparam logic [3:0] LastPos = 4'(BlockBytes - 1);

   // Work handed from the front to the back.
   typedef enum logic [1:0] {
      JOB_BLOCK,
      JOB_BLOCK_LAST,
      JOB_TAIL,
      JOB_EMPTY
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [31:0]  len;
      logic [95:0]  words;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic busy;
      logic result_load;
   } back_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MIX,
      BK_LEN,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } lanes_type;

   // One of the nine subtract/xor steps of the lookup2 mix.
   function automatic lanes_type jlh_mix_step(input logic [3:0] step, input lanes_type l);
      lanes_type r;
      r = l;
      case (step)
         4'd0: r.a = (l.a - l.b - l.c) ^ (l.c >> 13);
         4'd1: r.b = (l.b - l.c - l.a) ^ (l.a << 8);
         4'd2: r.c = (l.c - l.a - l.b) ^ (l.b >> 13);
         4'd3: r.a = (l.a - l.b - l.c) ^ (l.c >> 12);
         4'd4: r.b = (l.b - l.c - l.a) ^ (l.a << 16);
         4'd5: r.c = (l.c - l.a - l.b) ^ (l.b >> 5);
         4'd6: r.a = (l.a - l.b - l.c) ^ (l.c >> 3);
         4'd7: r.b = (l.b - l.c - l.a) ^ (l.a << 10);
         4'd8: r.c = (l.c - l.a - l.b) ^ (l.b >> 15);
         default: r = l;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/jenkins_lookup2_hash.sv */
// Lookup2 hash top level: one message byte per cycle in, one 32-bit hash per message out.
// Bytes are taken every cycle while the job queue has room; the mix engine handles each
// 12-byte block as a load and nine mix steps, so it keeps up with a stream's blocks.
// If a message's last byte ends a block, a second mix follows once the length is added.
// The front takes later bytes while the engine mixes, as long as the queue has room.
// Synchronous active-high reset clears the block, the lanes, the queue and rsp_tvalid.
`include "assert_macros.svh"

module jenkins_lookup2_hash #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // data_byte[7:0]
   input  logic        req_tlast,
   input  logic        req_tuser,    // empty_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata     // hash_value[31:0]
);
   import jlh_pkg::*;

   logic           q_push;
   logic           q_pop;
   job_type        push_job;
   job_type        head_job;
   queue_stat_type q_stat;
   back_stat_type  bk_stat;

   jlh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .push       (q_push),
      .push_job   (push_job)
   );

   jlh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .q_stat   (q_stat)
   );

   jlh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_stat     (q_stat),
      .pop        (q_pop),
      .bk_stat    (bk_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Check queue and engine interplay.
   `ASSERT_NEVER(a_push_full, clock, reset, q_push && q_stat.full, "job pushed into full queue")
   `ASSERT_NEVER(a_pop_empty, clock, reset, q_pop && q_stat.empty, "job popped from empty queue")
   `ASSERT_CLK(a_result_slot, clock, reset,
               bk_stat.result_load |-> (!rsp_tvalid || rsp_tready),
               "result overwrote pending transfer")
   `ASSERT_CLK(a_pop_idle, clock, reset, q_pop |=> bk_stat.busy,
               "engine not busy after taking a job")

endmodule

/* hw/rtl/jlh_front.sv */
// Front end: gathers bytes into 12-byte blocks and issues mix jobs.
module jlh_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // data_byte[7:0]
   input  logic                    req_tlast,
   input  logic                    req_tuser,   // empty_message
   input  jlh_pkg::queue_stat_type q_stat,
   output logic                    push,
   output jlh_pkg::job_type        push_job
);
   import jlh_pkg::*;

   logic [95:0] block_ff, block_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] len_ff, len_in;
   logic [95:0] block_fill;
   logic [31:0] len_next;
   logic        take;
   logic        full_blk;

   assign req_tready = !q_stat.full;
   assign take       = req_tvalid && req_tready;
   assign len_next   = len_ff + 32'd1;
   assign full_blk   = (pos_ff == LastPos);

   // Drop the byte into its lane of the block.
   always_comb begin
      block_fill = block_ff;
      for (int i = 0; i < BlockBytes; i++) begin
         if (pos_ff == 4'(i)) begin
            block_fill[i*8 +: 8] = req_tdata;
         end
      end
   end

   // Classify the transfer and advance the block state.
   always_comb begin
      block_in = block_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      push     = 1'b0;
      push_job = '{kind: JOB_BLOCK, len: len_next, words: block_fill};
      if (take) begin
         if (req_tuser) begin
            push     = 1'b1;
            push_job = '{kind: JOB_EMPTY, len: 32'd0, words: 96'd0};
            block_in = '0;
            pos_in   = '0;
            len_in   = '0;
         end else if (req_tlast) begin
            push          = 1'b1;
            push_job.kind = full_blk ? JOB_BLOCK_LAST : JOB_TAIL;
            block_in      = '0;
            pos_in        = '0;
            len_in        = '0;
         end else if (full_blk) begin
            push     = 1'b1;
            block_in = '0;
            pos_in   = '0;
            len_in   = len_next;
         end else begin
            block_in = block_fill;
            pos_in   = pos_ff + 4'd1;
            len_in   = len_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_ff <= '0;
         pos_ff   <= '0;
         len_ff   <= '0;
      end else begin
         block_ff <= block_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
      end
   end

endmodule

/* hw/rtl/jlh_queue.sv */
// Short job queue between the front end and the mix engine.
module jlh_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  jlh_pkg::job_type         push_job,
   input  logic                     pop,
   output jlh_pkg::job_type         head_job,
   output jlh_pkg::queue_stat_type  q_stat
);
   import jlh_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
   localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
   localparam logic [CntW-1:0] CntOne  = CntW'(1);

   job_type         mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign head_job     = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CntFull);
   assign q_stat.empty = (count_ff == '0);

   // Advance pointers and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrOne;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrOne;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CntOne;
         2'b01:   count_in = count_ff - CntOne;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the job at the write slot.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hw/rtl/jlh_back.sv */
// Mix engine: runs the lookup2 mix one step a cycle and holds the result.
module jlh_back (
   input  logic                    clock,
   input  logic                    reset,
   input  jlh_pkg::job_type        head_job,
   input  jlh_pkg::queue_stat_type q_stat,
   output logic                    pop,
   output jlh_pkg::back_stat_type  bk_stat,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata    // hash_value[31:0]
);
   import jlh_pkg::*;

   back_state_type state_ff, state_in;
   logic [3:0]     step_ff, step_in;
   job_kind_type   kind_ff, kind_in;
   logic [31:0]    len_ff, len_in;
   lanes_type      lanes_ff, lanes_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_data_ff, rsp_data_in;
   lanes_type      mix_out;
   logic           out_free;
   logic           result_load;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign mix_out    = jlh_mix_step(step_ff, lanes_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) state_in = BK_MIX;
         end
         BK_MIX: begin
            if (step_ff == LastStep) begin
               case (kind_ff) inside
                  JOB_BLOCK:            state_in = BK_IDLE;
                  JOB_BLOCK_LAST:       state_in = BK_LEN;
                  JOB_TAIL, JOB_EMPTY:  state_in = BK_DONE;
                  default:              state_in = BK_IDLE;
               endcase
            end
         end
         BK_LEN: state_in = BK_MIX;
         BK_DONE: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      pop         = 1'b0;
      result_load = 1'b0;
      unique case (state_ff)
         BK_IDLE: pop         = !q_stat.empty;
         BK_DONE: result_load = out_free;
         default: begin
            pop         = 1'b0;
            result_load = 1'b0;
         end
      endcase
   end

   assign bk_stat.busy        = (state_ff != BK_IDLE);
   assign bk_stat.result_load = result_load;

   // Lane datapath.
   always_comb begin
      lanes_in     = lanes_ff;
      step_in      = step_ff;
      kind_in      = kind_ff;
      len_in       = len_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               kind_in = head_job.kind;
               len_in  = head_job.len;
               step_in = '0;
               case (head_job.kind) inside
                  JOB_BLOCK, JOB_BLOCK_LAST: begin
                     lanes_in.a = lanes_ff.a + head_job.words[31:0];
                     lanes_in.b = lanes_ff.b + head_job.words[63:32];
                     lanes_in.c = lanes_ff.c + head_job.words[95:64];
                  end
                  JOB_TAIL: begin
                     lanes_in.a = lanes_ff.a + head_job.words[31:0];
                     lanes_in.b = lanes_ff.b + head_job.words[63:32];
                     lanes_in.c = lanes_ff.c + head_job.len
                                  + {head_job.words[87:64], 8'd0};
                  end
                  default: begin
                     lanes_in = '{a: Golden, b: Golden, c: 32'd0};
                  end
               endcase
            end
         end
         BK_MIX: begin
            lanes_in = mix_out;
            step_in  = (step_ff == LastStep) ? 4'd0 : step_ff + 4'd1;
         end
         BK_LEN: begin
            lanes_in.c = lanes_ff.c + len_ff;
            kind_in    = JOB_TAIL;
            step_in    = '0;
         end
         BK_DONE: begin
            if (result_load) begin
               rsp_data_in  = lanes_ff.c;
               rsp_valid_in = 1'b1;
               lanes_in     = '{a: Golden, b: Golden, c: 32'd0};
            end
         end
         default: lanes_in = lanes_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= '0;
         kind_ff      <= JOB_BLOCK;
         lanes_ff     <= '{a: Golden, b: Golden, c: 32'd0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         kind_ff      <= kind_in;
         lanes_ff     <= lanes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
